// ===== sv/bcmled_pkg.sv =====
// Shared types and constants for the BCM LED matrix refresher.
package bcmled_pkg;

  localparam int SIDE_DEF = 16;
  localparam int IN_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] FULL_MASK = 8'hff;
  localparam logic [3:0] NO_PLANE = 4'd8;
  localparam logic [3:0] DEPTH_RST = 4'd8;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK
  } st_t;

  typedef enum logic [1:0] {
    K_WRITE,
    K_READ,
    K_TICK
  } kind_t;

  typedef struct packed {
    logic [7:0] mask;
    logic       frame_done;
  } cd_stat_t;

endpackage

// ===== sv/bcmled_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bcmled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bcmled_cdown.sv =====
// Configuration registers and the bit-plane countdown with mask selection.
module bcmled_cdown (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bcmled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmled_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             tick,
  output bcmled_pkg::cd_stat_t             stat
);

  import bcmled_pkg::*;

  logic [7:0] tick_cnt_r, tick_cnt_nxt;
  logic [3:0] plane_r, plane_nxt;
  logic [3:0] depth_r, depth_nxt;
  logic       dmode_r, dmode_nxt;
  logic [3:0] new_depth;
  logic [7:0] mask;

  assign new_depth = cfg_data[3:0];

  always_comb begin
    if (dmode_r || depth_r <= 4'd1 || plane_r > 4'd7) begin
      mask = FULL_MASK;
    end else begin
      mask = 8'd1 << plane_r[2:0];
    end
  end

  assign stat.mask = mask;
  assign stat.frame_done = !dmode_r && (tick_cnt_r == 8'd0);

  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    plane_nxt = plane_r;
    depth_nxt = depth_r;
    dmode_nxt = dmode_r;
    if (cfg_we) begin
      if (cfg_index == CFG_GRAY_BITS) begin
        if (new_depth inside {[4'd1:4'd8]}) begin
          depth_nxt = new_depth;
          tick_cnt_nxt = 8'((9'd1 << new_depth) - 9'd2);
          plane_nxt = new_depth - 4'd1;
        end
      end else if (cfg_index == CFG_DISPLAY_MODE) begin
        dmode_nxt = cfg_data[0];
        if (!cfg_data[0]) begin
          tick_cnt_nxt = 8'((9'd1 << depth_r) - 9'd2);
          plane_nxt = depth_r - 4'd1;
        end else begin
          plane_nxt = NO_PLANE;
        end
      end
    end else if (tick && !dmode_r) begin
      if ((tick_cnt_r & mask) != 8'd0) begin
        tick_cnt_nxt = tick_cnt_r - 8'd1;
      end else if (tick_cnt_r != 8'd0) begin
        tick_cnt_nxt = tick_cnt_r - 8'd1;
        if (plane_r != 4'd0) begin
          plane_nxt = plane_r - 4'd1;
        end
      end else begin
        tick_cnt_nxt = 8'((9'd1 << depth_r) - 9'd2);
        plane_nxt = depth_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= 8'd0;
      plane_r <= NO_PLANE;
      depth_r <= DEPTH_RST;
      dmode_r <= 1'b1;
    end else begin
      tick_cnt_r <= tick_cnt_nxt;
      plane_r <= plane_nxt;
      depth_r <= depth_nxt;
      dmode_r <= dmode_nxt;
    end
  end

endmodule

// ===== sv/bcm_led_matrix_refresh.sv =====
// Top level of the BCM LED matrix refresher: sequencer, pixel memory and output stage.
//
// Channel  Direction  Beat contents
// in_      input      tdata: mode[1:0], row[5:2], col[9:6], pixel[17:10], zero pad
// out_     output     tdata: data[7:0]; tlast: last; tuser: frame_done
// cfg_     input      index 0 gray_bits, index 1 display_mode; data in cfg_data
//
// A refresh tick reads SIDE * ceil(SIDE/8) words (32 at the default size), one per
// output byte, through the single read port of the pixel memory, which holds one row
// of eight pixels per word. A pixel write does a read-modify-write of its word.
// After reset a clearing pass zeroes all SIDE * ceil(SIDE/8) words
// with in_tready low. A stalled out_tready holds the memory pipeline in place.
module bcm_led_matrix_refresh #(
  parameter int SIDE = bcmled_pkg::SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode[1:0], row[5:2], col[9:6], pixel[17:10], zeros[23:18]
  input  logic [bcmled_pkg::IN_W-1:0]       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // data[7:0]
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  // frame_done[0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcmled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmled_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bcmled_pkg::*;

  localparam int GROUPS = (SIDE + 7) / 8;
  localparam int DEPTH = SIDE * GROUPS;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(SIDE);
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WW = 64;

  st_t state_r, state_nxt;

  logic [1:0] in_mode;
  logic [3:0] in_row;
  logic [3:0] in_col;
  logic [7:0] in_pix;
  logic       in_range;
  logic       in_acc;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] tick_addr;

  logic [RW-1:0] r_r;
  logic [GW-1:0] g_r;
  logic [AW-1:0] clr_r;
  logic          tick_last;
  logic [7:0]    mask_r;
  logic          tick_done_r;

  logic          ram_vld_r;
  kind_t         ram_kind_r;
  logic [2:0]    ram_lane_r;
  logic          ram_zero_r;
  logic          ram_last_r;
  logic          ram_done_r;
  logic [AW-1:0] ram_addr_r;
  logic [7:0]    ram_pix_r;

  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_last_r;
  logic          out_done_r;

  logic          move;
  logic          issue_ok;
  logic          issue;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] merged;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [7:0]    plane_byte;
  logic [7:0]    read_byte;
  logic          cfg_we;
  cd_stat_t      cd_stat;

  assign in_mode = in_tdata[1:0];
  assign in_row = in_tdata[5:2];
  assign in_col = in_tdata[9:6];
  assign in_pix = in_tdata[17:10];
  assign in_range = (32'(in_row) < SIDE) && (32'(in_col) < SIDE);
  assign in_acc = in_tvalid && in_tready;
  assign pix_addr = AW'(32'(in_row) * GROUPS + 32'(in_col[3]));
  assign tick_addr = AW'(32'(r_r) * GROUPS + 32'(g_r));
  assign tick_last = (r_r == RW'(SIDE - 1)) && (g_r == GW'(GROUPS - 1));

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  bcmled_cdown u_cdown (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tick     (in_acc && in_mode == MODE_TICK),
    .stat     (cd_stat)
  );

  assign move = ram_vld_r && (ram_kind_r == K_WRITE || !out_valid_r || out_tready);
  assign issue_ok = !ram_vld_r || move;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_TICK) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        if (issue_ok && tick_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue = 1'b0;
    ram_raddr = pix_addr;
    case (state_r)
      ST_IDLE: begin
        in_tready = issue_ok && !(ram_vld_r && ram_kind_r == K_WRITE);
        issue = in_acc && (in_mode == MODE_READ || in_mode == MODE_TICK ||
                           (in_mode == MODE_WRITE && in_range));
        ram_raddr = (in_mode == MODE_TICK) ? AW'(0) : pix_addr;
      end
      ST_TICK: begin
        issue = issue_ok;
        ram_raddr = tick_addr;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      merged[8*i +: 8] = (3'(i) == ram_lane_r) ? ram_pix_r : ram_rdata[8*i +: 8];
      plane_byte[7-i] = |(ram_rdata[8*i +: 8] & mask_r);
    end
    read_byte = ram_zero_r ? 8'd0 : ram_rdata[{ram_lane_r, 3'b000} +: 8];
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we = ram_vld_r && ram_kind_r == K_WRITE;
      ram_waddr = ram_addr_r;
      ram_wdata = merged;
    end
  end

  bcmled_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      r_r <= '0;
      g_r <= '0;
      ram_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == ST_IDLE && in_acc && in_mode == MODE_TICK) begin
        r_r <= RW'(1);
        g_r <= '0;
      end else if (state_r == ST_TICK && issue) begin
        if (r_r == RW'(SIDE - 1)) begin
          r_r <= '0;
          g_r <= g_r + GW'(1);
        end else begin
          r_r <= r_r + RW'(1);
        end
      end
      if (issue) begin
        ram_vld_r <= 1'b1;
      end else if (move) begin
        ram_vld_r <= 1'b0;
      end
      if (move && ram_kind_r != K_WRITE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_mode == MODE_TICK) begin
      mask_r <= cd_stat.mask;
      tick_done_r <= cd_stat.frame_done;
    end
    if (issue) begin
      if (state_r == ST_TICK) begin
        ram_kind_r <= K_TICK;
        ram_last_r <= tick_last;
        ram_done_r <= tick_last && tick_done_r;
      end else begin
        case (in_mode)
          MODE_WRITE: ram_kind_r <= K_WRITE;
          MODE_READ:  ram_kind_r <= K_READ;
          default:    ram_kind_r <= K_TICK;
        endcase
        ram_last_r <= (in_mode != MODE_TICK);
        ram_done_r <= 1'b0;
      end
      ram_lane_r <= in_col[2:0];
      ram_zero_r <= !in_range;
      ram_addr_r <= pix_addr;
      ram_pix_r <= in_pix;
    end
    if (move && ram_kind_r != K_WRITE) begin
      out_data_r <= (ram_kind_r == K_TICK) ? plane_byte : read_byte;
      out_last_r <= ram_last_r;
      out_done_r <= ram_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_done_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the BCM LED matrix refresher: pixel traffic, refresh ticks, config.
`timescale 1ns / 1ps

module tb_top;
  import bcmled_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam int GROUPS = (SIDE + 7) / 8;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hfe;
  localparam int QUIET_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_done;
  } led_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bcm_led_matrix_refresh #(.SIDE(SIDE)) dut (.*);

  // Predicted block state.
  logic [7:0] pix_store [SIDE*SIDE];
  logic [7:0] tick_cnt;
  logic [3:0] plane;
  logic [3:0] depth;
  logic       disp_mode;

  logic [IN_W-1:0] beat_q[$];
  led_beat_t       led_bytes_q[$];

  int  err_cnt;
  bit  in_took;
  bit  idle_on;
  bit  hold_req;
  int  send_gap;
  int  stall_left;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_beat(logic [1:0] op, logic [3:0] row,
                                                logic [3:0] col, logic [7:0] pix);
    return {6'b0, pix, col, row, op};
  endfunction

  task automatic reload_countdown();
    tick_cnt = 8'((1 << depth) - 2);
    plane = depth - 4'd1;
  endtask

  task automatic matrix_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_GRAY_BITS: begin
        if (val[3:0] >= 4'd1 && val[3:0] <= 4'd8) begin
          depth = val[3:0];
          reload_countdown();
        end
      end
      CFG_DISPLAY_MODE: begin
        disp_mode = val[0];
        if (!disp_mode) reload_countdown();
        else plane = NO_PLANE;
      end
      default: ;
    endcase
  endtask

  task automatic matrix_step(logic [IN_W-1:0] beat);
    logic [1:0] op;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] pix;
    logic [7:0] mask;
    logic [7:0] row_bits;
    led_beat_t  b;
    bit         done;
    int         c;
    op = beat[1:0];
    row = beat[5:2];
    col = beat[9:6];
    pix = beat[17:10];
    case (op)
      MODE_WRITE: begin
        if (row < SIDE && col < SIDE) pix_store[row*SIDE + col] = pix;
      end
      MODE_READ: begin
        b.data = (row < SIDE && col < SIDE) ? pix_store[row*SIDE + col] : 8'h00;
        b.last = 1'b1;
        b.frame_done = 1'b0;
        led_bytes_q.push_back(b);
      end
      MODE_TICK: begin
        mask = (disp_mode || depth <= 4'd1 || plane > 4'd7) ? FULL_MASK : 8'(1 << plane);
        done = 1'b0;
        if (!disp_mode) begin
          if ((tick_cnt & mask) != 8'h00) begin
            tick_cnt = tick_cnt - 8'd1;
          end else if (tick_cnt != 8'h00) begin
            tick_cnt = tick_cnt - 8'd1;
            if (plane > 4'd0) plane = plane - 4'd1;
          end else begin
            reload_countdown();
            done = 1'b1;
          end
        end
        for (int g = 0; g < GROUPS; g++) begin
          for (int r = 0; r < SIDE; r++) begin
            row_bits = 8'h00;
            for (int k = 0; k < 8; k++) begin
              c = g*8 + k;
              row_bits = {row_bits[6:0], c < SIDE && (pix_store[r*SIDE + c] & mask) != 8'h00};
            end
            b.data = row_bits;
            b.last = (g == GROUPS - 1) && (r == SIDE - 1);
            b.frame_done = b.last && done;
            led_bytes_q.push_back(b);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_miss(string what, led_beat_t want, led_beat_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s: expected data %02h last %0b frame_done %0b, got data %02h last %0b frame_done %0b",
               $realtime, what, want.data, want.last, want.frame_done,
               got.data, got.last, got.frame_done);
  endtask

  // Monitor: observe all three channels at the rising edge.
  always @(posedge clk) begin
    led_beat_t got;
    led_beat_t want;
    in_took = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) matrix_cfg(cfg_index, cfg_data);
      if (in_took) matrix_step(in_tdata);
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, last: out_tlast, frame_done: out_tuser};
        if (led_bytes_q.size() == 0) begin
          report_miss("unexpected beat", '0, got);
        end else begin
          want = led_bytes_q.pop_front();
          if (got != want) report_miss("beat mismatch", want, got);
        end
      end
    end
  end

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (beat_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 6) - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= beat_q.pop_front();
        in_tvalid <= 1'b1;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (beat_q.size() != 0 || in_tvalid || led_bytes_q.size() != 0 || hold_left > 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(int n, int tick_pct);
    int         pick;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) op = MODE_TICK;
      else if (pick < tick_pct + 5) op = MODE_NONE;
      else if (pick % 3 == 0) op = MODE_READ;
      else op = MODE_WRITE;
      beat_q.push_back(pack_beat(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic run_phase(logic [7:0] depth_val, logic [7:0] mode_val, int n, int tick_pct,
                           bit idle, bit hold);
    write_reg(CFG_GRAY_BITS, depth_val);
    write_reg(CFG_DISPLAY_MODE, mode_val);
    idle_on = idle;
    if (hold) hold_req = 1'b1;
    push_random(n, tick_pct);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_cnt = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    for (int i = 0; i < SIDE*SIDE; i++) pix_store[i] = 8'h00;
    tick_cnt = 8'h00;
    plane = NO_PLANE;
    depth = DEPTH_RST;
    disp_mode = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners, all pixel bits, reads of cleared pixels, static tick, unused mode.
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd0, 4'd0, 8'hff));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd15, 4'd15, 8'h01));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd0, 4'd15, 8'h80));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd15, 4'd0, 8'h06));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd7, 4'd8, 8'ha5));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd8, 4'd7, 8'h5a));
    beat_q.push_back(pack_beat(MODE_WRITE, 4'd3, 4'd12, 8'h00));
    beat_q.push_back(pack_beat(MODE_READ, 4'd0, 4'd0, 8'h00));
    beat_q.push_back(pack_beat(MODE_READ, 4'd15, 4'd15, 8'hff));
    beat_q.push_back(pack_beat(MODE_READ, 4'd0, 4'd15, 8'h00));
    beat_q.push_back(pack_beat(MODE_READ, 4'd2, 4'd2, 8'h00));
    beat_q.push_back(pack_beat(MODE_TICK, 4'd0, 4'd0, 8'h00));
    beat_q.push_back(pack_beat(MODE_NONE, 4'd15, 4'd15, 8'hff));
    beat_q.push_back(pack_beat(MODE_TICK, 4'd9, 4'd5, 8'h3c));
    drain();

    // One full grayscale frame at depth 3; bad depth values and an unused index are ignored.
    write_reg(CFG_DISPLAY_MODE, 8'hfe);
    write_reg(CFG_GRAY_BITS, 8'h03);
    write_reg(CFG_GRAY_BITS, 8'h00);
    write_reg(CFG_GRAY_BITS, 8'h09);
    write_reg(CFG_GRAY_BITS, 8'hff);
    write_reg(CFG_UNUSED, 8'h55);
    for (int i = 0; i < 8; i++) beat_q.push_back(pack_beat(MODE_TICK, 4'd0, 4'd0, 8'h00));
    drain();

    run_phase(8'hf1, 8'hfe, 50, 30, 1'b1, 1'b0);
    run_phase(8'h08, 8'h00, 40, 40, 1'b1, 1'b1);
    run_phase(8'h02, 8'h00, 40, 40, 1'b0, 1'b0);
    run_phase(8'h06, 8'h00, 75, 85, 1'b1, 1'b0);
    run_phase(8'h04, 8'h01, 40, 30, 1'b1, 1'b0);
    run_phase(8'h05, 8'h00, 50, 50, 1'b1, 1'b0);
    run_phase(8'h03, 8'h00, 40, 50, 1'b0, 1'b0);

    if (err_cnt == 0 && led_bytes_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
